/* hdl/dpfe_pkg.sv */
package dpfe_pkg;

   localparam logic OP_PAYLOAD = 1'b0;
   localparam logic OP_ACK     = 1'b1;

   localparam logic [7:0] FRAME_TYPE_BYTE = 8'h08;
   localparam logic [2:0] TAG_WIRE_TYPE   = 3'd2;

   typedef struct packed {
      logic        opcode;
      logic [28:0] field_number;
      logic [4:0]  message_length;
      logic [7:0]  data_byte;
      logic        last_element;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       status;
      logic       last_of_frame;
   } rsp_type;

   // one pending piece of output: either a full header (plus optional data
   // byte), a lone data byte, or a rejection
   typedef struct packed {
      logic        header;
      logic        reject;
      logic        has_data;
      logic        data_last;
      logic [7:0]  data_byte;
      logic [31:0] cmd;
      logic [2:0]  cmd_len;
      logic [31:0] tag;
      logic [2:0]  tag_len;
      logic [4:0]  msg_len;
      logic [6:0]  body;
   } job_type;

   typedef enum logic [5:0] {
      SEG_BODY = 6'b000001,
      SEG_TYPE = 6'b000010,
      SEG_CMD  = 6'b000100,
      SEG_TAG  = 6'b001000,
      SEG_LEN  = 6'b010000,
      SEG_DATA = 6'b100000
   } seg_type;

   // number of base-128 groups needed for a 32-bit value (1..5)
   function automatic logic [2:0] varint_len(input logic [31:0] v);
      logic [2:0] n;
      if (v[31:28] != 4'd0) begin
         n = 3'd5;
      end else if (v[27:21] != 7'd0) begin
         n = 3'd4;
      end else if (v[20:14] != 7'd0) begin
         n = 3'd3;
      end else if (v[13:7] != 7'd0) begin
         n = 3'd2;
      end else begin
         n = 3'd1;
      end
      return n;
   endfunction

   // group idx of a varint of n groups, with the continuation bit
   function automatic logic [7:0] varint_byte(input logic [31:0] v,
                                              input logic [2:0]  idx,
                                              input logic [2:0]  n);
      logic [6:0] g;
      logic       cont;
      case (idx)
         3'd0:    g = v[6:0];
         3'd1:    g = v[13:7];
         3'd2:    g = v[20:14];
         3'd3:    g = v[27:21];
         default: g = {3'b000, v[31:28]};
      endcase
      cont = (({1'b0, idx} + 4'd1) < {1'b0, n});
      return {cont, g};
   endfunction

endpackage

/* hdl/dpfe_emitter.sv */
module dpfe_emitter (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  dpfe_pkg::job_type job,
   output logic              ready,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dpfe_pkg::rsp_type rsp_word
);
   import dpfe_pkg::*;

   logic    job_valid_ff, job_valid_in;
   job_type job_ff;
   seg_type seg_ff, seg_in;
   logic [2:0] idx_ff, idx_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, cur;
   logic    advance, final_byte;

   assign advance = job_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign ready   = !job_valid_ff || (advance && final_byte);

   // current byte of the job and where the walk goes next
   always_comb begin
      cur        = '0;
      final_byte = 1'b0;
      seg_in     = seg_ff;
      idx_in     = idx_ff;
      case (seg_ff)
         SEG_BODY: begin
            cur.out_byte = {1'b0, job_ff.body};
            seg_in       = SEG_TYPE;
         end
         SEG_TYPE: begin
            cur.out_byte = FRAME_TYPE_BYTE;
            seg_in       = SEG_CMD;
            idx_in       = 3'd0;
         end
         SEG_CMD: begin
            cur.out_byte = varint_byte(job_ff.cmd, idx_ff, job_ff.cmd_len);
            if (({1'b0, idx_ff} + 4'd1) == {1'b0, job_ff.cmd_len}) begin
               seg_in = SEG_TAG;
               idx_in = 3'd0;
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end
         SEG_TAG: begin
            cur.out_byte = varint_byte(job_ff.tag, idx_ff, job_ff.tag_len);
            if (({1'b0, idx_ff} + 4'd1) == {1'b0, job_ff.tag_len}) begin
               seg_in = SEG_LEN;
               idx_in = 3'd0;
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end
         SEG_LEN: begin
            cur.out_byte      = {3'b000, job_ff.msg_len};
            cur.last_of_frame = !job_ff.has_data;
            final_byte        = !job_ff.has_data;
            seg_in            = SEG_DATA;
         end
         SEG_DATA: begin
            if (job_ff.reject) begin
               cur.out_byte      = 8'h00;
               cur.status        = 1'b1;
               cur.last_of_frame = 1'b1;
            end else begin
               cur.out_byte      = job_ff.data_byte;
               cur.last_of_frame = job_ff.data_last;
            end
            final_byte = 1'b1;
         end
         default: begin
            final_byte = 1'b1;
         end
      endcase
   end

   always_comb begin
      job_valid_in = job_valid_ff;
      if (load) begin
         job_valid_in = 1'b1;
      end else if (advance && final_byte) begin
         job_valid_in = 1'b0;
      end
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seg_ff       <= SEG_DATA;
         idx_ff       <= 3'd0;
      end else begin
         job_valid_ff <= job_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            seg_ff <= job.header ? SEG_BODY : SEG_DATA;
            idx_ff <= 3'd0;
         end else if (advance) begin
            seg_ff <= seg_in;
            idx_ff <= idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         job_ff <= job;
      end
      if (advance) begin
         rsp_ff <= cur;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

/* hdl/delimited_protobuf_frame_encoder.sv */
// Length-delimited protobuf frame encoder.
// req channel: one word per payload item (opcode 0) or a write acknowledge
// (opcode 1). The first payload word of a request produces the frame header
// (body length, 0x08, command id varint, tag varint, payload length) and then
// its own data byte; later words pass their byte straight through.
// rsp channel: one frame byte per word; a refused request gives one word with
// status set and the rest of its words are swallowed.
// csr port: link_ready, written with csr_wr_en.
// Timing: the input word is captured in the job register, and its first byte
// then moves to the output byte register. Payload words stream at one per
// cycle while rsp_stall is low; a header word occupies the output for its body
// length, 0x08, command id varint, tag varint and payload length bytes, plus
// its data byte when the payload is not empty, and req_stall is held high
// until its last byte goes out. The output byte register and the one-entry job
// register in the emitter set this timing. Reset: command id back to 1, no
// write pending, link not ready, no request open. When rsp_stall is high the
// output word holds and a full job register keeps req_stall high until it drains.
module delimited_protobuf_frame_encoder #(
   parameter int MAX_PAYLOAD = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dpfe_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dpfe_pkg::rsp_type rsp_word,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);
   import dpfe_pkg::*;

   logic        cmd_ok;
   logic [31:0] cmd_ff, cmd_in;
   logic        pend_ff, pend_in;
   logic        inreq_ff, inreq_in;
   logic        drop_ff, drop_in;
   logic [4:0]  remain_ff, remain_in;
   logic        link_ff;

   logic        em_ready, accept, load;
   job_type     job;
   logic [31:0] tag;
   logic [2:0]  cmd_len, tag_len;
   logic [4:0]  len;

   assign req_stall = !em_ready;
   assign accept    = req_valid && em_ready;
   assign len       = req_word.message_length;
   assign tag       = {req_word.field_number, TAG_WIRE_TYPE};
   assign cmd_len   = varint_len(cmd_ff);
   assign tag_len   = varint_len(tag);
   assign cmd_ok    = link_ff && !pend_ff && ({2'b00, len} <= 7'(MAX_PAYLOAD));

   always_comb begin
      cmd_in    = cmd_ff;
      pend_in   = pend_ff;
      inreq_in  = inreq_ff;
      drop_in   = drop_ff;
      remain_in = remain_ff;
      load      = 1'b0;

      job           = '0;
      job.data_byte = req_word.data_byte;
      job.cmd       = cmd_ff;
      job.cmd_len   = cmd_len;
      job.tag       = tag;
      job.tag_len   = tag_len;
      job.msg_len   = len;
      job.body      = 7'd2 + {4'b0000, cmd_len} + {4'b0000, tag_len} + {2'b00, len};

      if (accept) begin
         if (req_word.opcode == OP_ACK) begin
            pend_in = 1'b0;
         end else if (inreq_ff) begin
            if (drop_ff) begin
               if (req_word.last_element) begin
                  inreq_in = 1'b0;
                  drop_in  = 1'b0;
               end
            end else begin
               if (remain_ff != 5'd0) begin
                  load          = 1'b1;
                  job.has_data  = 1'b1;
                  job.data_last = (remain_ff == 5'd1) || req_word.last_element;
                  remain_in     = remain_ff - 5'd1;
               end
               if (req_word.last_element) begin
                  remain_in = 5'd0;
                  inreq_in  = 1'b0;
               end
            end
         end else if (!cmd_ok) begin
            load       = 1'b1;
            job.reject = 1'b1;
            if (!req_word.last_element) begin
               inreq_in = 1'b1;
               drop_in  = 1'b1;
            end
         end else begin
            load          = 1'b1;
            job.header    = 1'b1;
            job.has_data  = (len != 5'd0);
            job.data_last = (len == 5'd1) || req_word.last_element;
            cmd_in        = cmd_ff + 32'd1;
            pend_in       = 1'b1;
            remain_in     = (req_word.last_element || len == 5'd0) ? 5'd0 : len - 5'd1;
            inreq_in      = !req_word.last_element;
            drop_in       = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff    <= 32'd1;
         pend_ff   <= 1'b0;
         inreq_ff  <= 1'b0;
         drop_ff   <= 1'b0;
         remain_ff <= 5'd0;
         link_ff   <= 1'b0;
      end else begin
         cmd_ff    <= cmd_in;
         pend_ff   <= pend_in;
         inreq_ff  <= inreq_in;
         drop_ff   <= drop_in;
         remain_ff <= remain_in;
         if (csr_wr_en) begin
            link_ff <= csr_wr_data;
         end
      end
   end

   dpfe_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .job       (job),
      .ready     (em_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule
